// ===== hw/rtl/axis_angle_unwrap_sensor_macros.svh =====
// assertion helpers for the angle unwrap sensor
`ifndef AXIS_ANGLE_UNWRAP_SENSOR_MACROS_SVH
`define AXIS_ANGLE_UNWRAP_SENSOR_MACROS_SVH

// same-cycle implication, held off during reset
`define AAUS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define AAUS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/aaus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aaus_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ACC_WIDTH       = 40;
  localparam int ZFRAC           = 20;
  localparam int TABLE_LEN       = 24;

  // widths of the internal values
  localparam int VW   = 16;               // input component
  localparam int DOTW = 33;               // a.s
  localparam int PW   = 21;               // projected component
  localparam int CW   = 38;               // cross product component
  localparam int OPAW = 39;               // wide multiplier operand
  localparam int PRW  = OPAW + VW;        // product
  localparam int ACW  = PRW + 2;          // multiply accumulator
  localparam int XYW  = 60;               // cordic x and y
  localparam int ZW   = 30;               // cordic angle, degrees * 2^20
  localparam int ANGW = ANGLE_FRAC_BITS + 11;
  localparam int DW   = ANGW + 1;
  localparam int WRW  = 17;               // wrapped angle port width
  localparam int ITW  = 5;                // cordic step counter
  localparam int OPW  = 5;                // multiply op counter
  localparam int NOPS = 18;

  localparam int HALF_TURN = 180 * (1 << ANGLE_FRAC_BITS);
  localparam int FULL_TURN = 360 * (1 << ANGLE_FRAC_BITS);
  localparam int RSH       = ZFRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PRE,
    ST_ROT,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/axis_angle_unwrap_sensor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Angle unwrap sensor. Each input item carries a sensed vector, a reference
// vector and a rotation axis (Q1.14). The block projects the sensed vector
// onto the plane normal to the axis, takes the signed angle from that
// projection to the reference with a 16-step vectoring CORDIC (1/256 degree
// units, +90 degrees when the projection or reference is zero), wraps the
// change from the last angle into [-180,180) and adds it to a 40-bit
// saturating total. One signed 39x16 multiplier is shared by all 18 products
// of the vector math, each taking a multiply step and an accumulate step,
// then come a setup step, one cordic rotation per cycle and a finish step;
// the zero case (projection or reference zero) skips the rotations.
// in_tready is high only while idle, from the cycle after the result is
// loaded, so a new item is taken only once the last item's result is
// loaded. A result waits in the output register while the next item is
// computed; the finish step stalls only while that register still holds
// an unaccepted result.
module axis_angle_unwrap_sensor (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // sensed_x, sensed_y, sensed_z, ref_x, ref_y, ref_z, axis_x, axis_y, axis_z
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // total_angle[39:0], wrapped_angle[56:40], zero pad
  output logic [63:0]       out_tdata,
  // saturated
  output logic              out_tuser
);

  localparam int AW  = aaus_pkg::ACC_WIDTH;
  localparam int DW  = aaus_pkg::DW;
  localparam int XYW = aaus_pkg::XYW;
  localparam int ZW  = aaus_pkg::ZW;

  aaus_pkg::state_t state_r, state_nxt;

  // input item
  logic signed [aaus_pkg::VW-1:0]  s_r [3];
  logic signed [aaus_pkg::VW-1:0]  r_r [3];
  logic signed [aaus_pkg::VW-1:0]  a_r [3];

  // vector math
  logic [aaus_pkg::OPW-1:0]         op_r;
  logic signed [aaus_pkg::PRW-1:0]  prod_r;
  logic signed [aaus_pkg::ACW-1:0]  acc_r;
  logic signed [aaus_pkg::DOTW-1:0] dot_r;
  logic signed [aaus_pkg::PW-1:0]   p_r [3];
  logic signed [aaus_pkg::CW-1:0]   c_r [3];

  // cordic
  logic signed [XYW-1:0]            x_r, y_r;
  logic signed [ZW-1:0]             z_r;
  logic [aaus_pkg::ITW-1:0]         it_r;
  logic                             zero_r;

  // running state
  logic signed [AW-1:0]             total_r;
  logic signed [aaus_pkg::WRW-1:0]  last_r;

  // output register
  logic                             out_valid_r;
  logic [AW-1:0]                    out_total_r;
  logic [aaus_pkg::WRW-1:0]         out_wrap_r;
  logic                             out_sat_r;

  logic signed [aaus_pkg::OPAW-1:0] opa;
  logic signed [aaus_pkg::VW-1:0]   opb;
  logic signed [aaus_pkg::ACW-1:0]  prod_x;
  logic signed [aaus_pkg::ACW-1:0]  acc_sum;
  logic signed [aaus_pkg::ACW-1:0]  acc_dif;
  logic signed [aaus_pkg::ACW-1:0]  p_full;
  logic signed [XYW-1:0]            xs, ys;
  logic signed [ZW-1:0]             z_rnd;
  logic signed [aaus_pkg::ANGW-1:0] ang;
  logic signed [DW-1:0]             dv;
  logic signed [DW-1:0]             lw;
  logic signed [AW:0]               sum;
  logic signed [AW-1:0]             total_new;
  logic                             sat_new;
  logic                             in_acc, out_free;

  assign in_tready  = (state_r == aaus_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_wrap_r, out_total_r};
  assign out_tuser  = out_sat_r;

  // operand select for the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      5'd0:  begin opa = aaus_pkg::OPAW'(s_r[0]); opb = a_r[0]; end
      5'd1:  begin opa = aaus_pkg::OPAW'(s_r[1]); opb = a_r[1]; end
      5'd2:  begin opa = aaus_pkg::OPAW'(s_r[2]); opb = a_r[2]; end
      5'd3:  begin opa = aaus_pkg::OPAW'(dot_r); opb = a_r[0]; end
      5'd4:  begin opa = aaus_pkg::OPAW'(dot_r); opb = a_r[1]; end
      5'd5:  begin opa = aaus_pkg::OPAW'(dot_r); opb = a_r[2]; end
      5'd6:  begin opa = aaus_pkg::OPAW'(p_r[1]); opb = r_r[2]; end
      5'd7:  begin opa = aaus_pkg::OPAW'(p_r[2]); opb = r_r[1]; end
      5'd8:  begin opa = aaus_pkg::OPAW'(p_r[2]); opb = r_r[0]; end
      5'd9:  begin opa = aaus_pkg::OPAW'(p_r[0]); opb = r_r[2]; end
      5'd10: begin opa = aaus_pkg::OPAW'(p_r[0]); opb = r_r[1]; end
      5'd11: begin opa = aaus_pkg::OPAW'(p_r[1]); opb = r_r[0]; end
      5'd12: begin opa = aaus_pkg::OPAW'(c_r[0]); opb = a_r[0]; end
      5'd13: begin opa = aaus_pkg::OPAW'(c_r[1]); opb = a_r[1]; end
      5'd14: begin opa = aaus_pkg::OPAW'(c_r[2]); opb = a_r[2]; end
      5'd15: begin opa = aaus_pkg::OPAW'(p_r[0]); opb = r_r[0]; end
      5'd16: begin opa = aaus_pkg::OPAW'(p_r[1]); opb = r_r[1]; end
      5'd17: begin opa = aaus_pkg::OPAW'(p_r[2]); opb = r_r[2]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // accumulate side and the projection rounding
  always_comb begin
    prod_x  = aaus_pkg::ACW'(prod_r);
    acc_sum = acc_r + prod_x;
    acc_dif = acc_r - prod_x;
    p_full  = '0;
    case (op_r)
      5'd3:    p_full = (aaus_pkg::ACW'(s_r[0]) <<< 28) - prod_x + (aaus_pkg::ACW'(1) <<< 27);
      5'd4:    p_full = (aaus_pkg::ACW'(s_r[1]) <<< 28) - prod_x + (aaus_pkg::ACW'(1) <<< 27);
      5'd5:    p_full = (aaus_pkg::ACW'(s_r[2]) <<< 28) - prod_x + (aaus_pkg::ACW'(1) <<< 27);
      default: p_full = '0;
    endcase
  end

  // cordic shifts, rounding, wrap and saturating add
  always_comb begin
    xs    = x_r >>> it_r;
    ys    = y_r >>> it_r;
    z_rnd = (z_r + (ZW'(1) <<< (aaus_pkg::RSH - 1))) >>> aaus_pkg::RSH;
    if (zero_r) begin
      ang = aaus_pkg::ANGW'(90 * (1 << aaus_pkg::ANGLE_FRAC_BITS));
    end else begin
      ang = z_rnd[aaus_pkg::ANGW-1:0];
    end
    dv = DW'(ang) - DW'(last_r);
    if (dv >= DW'(aaus_pkg::HALF_TURN)) dv = dv - DW'(aaus_pkg::FULL_TURN);
    if (dv < DW'(-aaus_pkg::HALF_TURN)) dv = dv + DW'(aaus_pkg::FULL_TURN);
    lw = DW'(last_r) + dv;
    if (lw >= DW'(aaus_pkg::HALF_TURN)) lw = lw - DW'(aaus_pkg::FULL_TURN);
    if (lw < DW'(-aaus_pkg::HALF_TURN)) lw = lw + DW'(aaus_pkg::FULL_TURN);
    sum = (AW+1)'(total_r) + (AW+1)'(dv);
    sat_new   = 1'b0;
    total_new = sum[AW-1:0];
    // top two bits differ when the sum leaves the total's range
    if (!sum[AW] && sum[AW-1]) begin
      total_new = {1'b0, {(AW-1){1'b1}}};
      sat_new   = 1'b1;
    end else if (sum[AW] && !sum[AW-1]) begin
      total_new = {1'b1, {(AW-1){1'b0}}};
      sat_new   = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aaus_pkg::ST_IDLE: if (in_acc) state_nxt = aaus_pkg::ST_MUL;
      aaus_pkg::ST_MUL:  state_nxt = aaus_pkg::ST_ACC;
      aaus_pkg::ST_ACC: begin
        if (op_r == aaus_pkg::OPW'(aaus_pkg::NOPS - 1)) state_nxt = aaus_pkg::ST_PRE;
        else state_nxt = aaus_pkg::ST_MUL;
      end
      aaus_pkg::ST_PRE: begin
        if (x_r == '0 && y_r == '0) state_nxt = aaus_pkg::ST_FIN;
        else state_nxt = aaus_pkg::ST_ROT;
      end
      aaus_pkg::ST_ROT: begin
        if (it_r == aaus_pkg::ITW'(aaus_pkg::CORDIC_STEPS - 1)) state_nxt = aaus_pkg::ST_FIN;
      end
      aaus_pkg::ST_FIN:  if (out_free) state_nxt = aaus_pkg::ST_IDLE;
      default:           state_nxt = aaus_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aaus_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state: running totals and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == aaus_pkg::ST_FIN && out_free) begin
        total_r     <= total_new;
        last_r      <= lw[aaus_pkg::WRW-1:0];
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      aaus_pkg::ST_IDLE: begin
        if (in_acc) begin
          for (int k = 0; k < 3; k++) begin
            s_r[k] <= in_tdata[16*k +: 16];
            r_r[k] <= in_tdata[48 + 16*k +: 16];
            a_r[k] <= in_tdata[96 + 16*k +: 16];
          end
        end
        op_r <= '0;
      end
      aaus_pkg::ST_MUL: prod_r <= opa * opb;
      aaus_pkg::ST_ACC: begin
        op_r <= op_r + aaus_pkg::OPW'(1);
        case (op_r)
          5'd0, 5'd6, 5'd8, 5'd10, 5'd12, 5'd15: acc_r <= prod_x;
          5'd1, 5'd13, 5'd16:                    acc_r <= acc_sum;
          5'd2:  dot_r  <= acc_sum[aaus_pkg::DOTW-1:0];
          5'd3:  p_r[0] <= p_full[28 +: aaus_pkg::PW];
          5'd4:  p_r[1] <= p_full[28 +: aaus_pkg::PW];
          5'd5:  p_r[2] <= p_full[28 +: aaus_pkg::PW];
          5'd7:  c_r[0] <= acc_dif[aaus_pkg::CW-1:0];
          5'd9:  c_r[1] <= acc_dif[aaus_pkg::CW-1:0];
          5'd11: c_r[2] <= acc_dif[aaus_pkg::CW-1:0];
          5'd14: y_r    <= XYW'(acc_sum);
          5'd17: x_r    <= XYW'(acc_sum) <<< 14;
          default: acc_r <= acc_r;
        endcase
      end
      aaus_pkg::ST_PRE: begin
        zero_r <= (x_r == '0 && y_r == '0);
        it_r   <= '0;
        z_r    <= '0;
        if (x_r < 0) begin
          if (y_r >= 0) begin
            x_r <= y_r;
            y_r <= -x_r;
            z_r <= ZW'(90 * (1 << aaus_pkg::ZFRAC));
          end else begin
            x_r <= -y_r;
            y_r <= x_r;
            z_r <= ZW'(-90 * (1 << aaus_pkg::ZFRAC));
          end
        end
      end
      aaus_pkg::ST_ROT: begin
        it_r <= it_r + aaus_pkg::ITW'(1);
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + aaus_pkg::ATAN_TAB[it_r];
        end else if (y_r < 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - aaus_pkg::ATAN_TAB[it_r];
        end
      end
      aaus_pkg::ST_FIN: begin
        if (out_free) begin
          out_total_r <= total_new;
          out_wrap_r  <= lw[aaus_pkg::WRW-1:0];
          out_sat_r   <= sat_new;
        end
      end
      default: op_r <= op_r;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aaus_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "axis_angle_unwrap_sensor_macros.svh"
module aaus_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic         out_tuser
);

  localparam logic [39:0] TOT_MAX = 40'h7fffffffff;
  localparam logic [39:0] TOT_MIN = 40'h8000000000;

  logic signed [16:0] wrap_v;
  logic [39:0]        tot_v;

  assign wrap_v = out_tdata[56:40];
  assign tot_v  = out_tdata[39:0];

  // the block is busy after taking an item
  `AAUS_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // a stalled result holds
  `AAUS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // wrapped angle stays within a half turn
  `AAUS_ASSERT_IMP(a_wrap_range, out_tvalid, (wrap_v >= -17'sd46080) && (wrap_v <= 17'sd46079))

  // clipping leaves the total at one of its limits
  `AAUS_ASSERT_IMP(a_sat_limit, out_tvalid && out_tuser, (tot_v == TOT_MAX) || (tot_v == TOT_MIN))

endmodule

bind axis_angle_unwrap_sensor aaus_checker u_aaus_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
